// ----- sv/kdrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kdrp_pkg
// Shared types, constants and key code table for the keypad debounce,
// record and playback controller.
// ----------------------------------------------------------------------------
package kdrp_pkg;

   // record store size and derived widths
   localparam int RECORD_DEPTH = 100;
   localparam int CNT_W        = $clog2(RECORD_DEPTH + 1);
   localparam int ADDR_W       = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(RECORD_DEPTH);

   // keypad decode
   localparam int KEY_COUNT = 12;
   localparam logic [6:0] COLUMN_MASK = 7'h70;
   localparam logic [3:0] NO_KEY      = 4'd15;
   localparam logic [6:0] CODE_TABLE [KEY_COUNT] = '{
      7'h28, 7'h11, 7'h21, 7'h41, 7'h12, 7'h22,
      7'h42, 7'h14, 7'h24, 7'h44, 7'h18, 7'h48
   };

   // keys with a function
   localparam logic [3:0] KEY_SWOOP   = 4'd1;
   localparam logic [3:0] KEY_SILENCE = 4'd3;
   localparam logic [3:0] KEY_RECORD  = 4'd10;
   localparam logic [3:0] KEY_PLAY    = 4'd11;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_MAYBE_ON  = 2'd1,
      ST_MAYBE_OFF = 2'd2,
      ST_ON        = 2'd3
   } press_state_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_SWOOP   = 2'd1,
      CMD_CHIRP   = 2'd2,
      CMD_SILENCE = 2'd3
   } sound_cmd_type;

   // debounce -> sequencer / result
   typedef struct packed {
      logic            confirm;
      logic [3:0]      key;
      press_state_type state;
   } press_info_type;

   // sequencer -> result
   typedef struct packed {
      sound_cmd_type    cmd;
      logic             recording;
      logic             playing;
      logic [CNT_W-1:0] count;
   } seq_status_type;

endpackage
`default_nettype wire

// ----- sv/kdrp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kdrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kdrp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 100,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- sv/kdrp_debounce.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kdrp_debounce
// Scan decode through the code table and the four-state press debouncer.
// ----------------------------------------------------------------------------
module kdrp_debounce (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic [6:0]              scan_bits,
   output kdrp_pkg::press_info_type     press_info
);
   import kdrp_pkg::*;

   press_state_type state_ff, state_in;
   logic [3:0]      cand_ff, cand_in;
   logic [3:0]      key;
   logic            confirm;

   function automatic logic [3:0] decode_scan(input logic [6:0] scan);
      logic [3:0] k;
      k = NO_KEY;
      if ((scan & COLUMN_MASK) != 7'd0) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            if (scan == CODE_TABLE[i]) begin
               k = 4'(i);
            end
         end
      end
      return k;
   endfunction

   assign key = decode_scan(scan_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cand_ff  <= NO_KEY;
      end else if (advance) begin
         state_ff <= state_in;
         cand_ff  <= cand_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cand_in  = cand_ff;
      confirm  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (key != NO_KEY) begin
               cand_in  = key;
               state_in = ST_MAYBE_ON;
            end
         end
         ST_MAYBE_ON: begin
            if (key == cand_ff) begin
               state_in = ST_ON;
               confirm  = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAYBE_OFF: begin
            state_in = (key == cand_ff) ? ST_ON : ST_IDLE;
         end
         ST_ON: begin
            state_in = (key != cand_ff) ? ST_MAYBE_OFF : ST_ON;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign press_info.confirm = confirm;
   assign press_info.key     = key;
   assign press_info.state   = state_in;

endmodule
`default_nettype wire

// ----- sv/kdrp_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kdrp_sequencer
// Command issue, record store append and playback from the record store.
// ----------------------------------------------------------------------------
module kdrp_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 sound_busy,
   input  kdrp_pkg::press_info_type  press_info,
   output kdrp_pkg::seq_status_type  status
);
   import kdrp_pkg::*;

   logic             rec_on_ff, rec_on_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             play_on_ff, play_on_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [1:0]       first_ff;          // copy of entry 0 for the play-start read
   logic             byp_ff;
   logic [1:0]       byp_data_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [1:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [1:0]        rd_data;
   logic [1:0]        entry;
   logic              start;
   sound_cmd_type     cmd;

   kdrp_ram #(
      .WIDTH (2),
      .DEPTH (RECORD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the RAM reads before it writes; forward a write to the entry being fetched
   assign entry   = byp_ff ? byp_data_ff : rd_data;
   assign rd_addr = pos_in[ADDR_W-1:0];

   always_comb begin
      rec_on_in  = rec_on_ff;
      count_in   = count_ff;
      play_on_in = play_on_ff;
      pos_in     = pos_ff;
      cmd        = CMD_NONE;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = press_info.key[1:0];
      start      = 1'b0;

      if (advance && press_info.confirm) begin
         if (press_info.key >= KEY_SWOOP && press_info.key <= KEY_SILENCE) begin
            cmd = sound_cmd_type'(press_info.key[1:0]);
            if (rec_on_ff && count_ff < DEPTH_COUNT) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else if (count_ff == DEPTH_COUNT) begin
               // full store wraps the count and drops out of record mode
               count_in  = '0;
               rec_on_in = 1'b0;
            end
         end else if (press_info.key == KEY_RECORD) begin
            rec_on_in = !rec_on_ff;
            if (!rec_on_ff) begin
               count_in = '0;
            end
         end else if (press_info.key == KEY_PLAY) begin
            if (count_ff != '0) begin
               play_on_in = 1'b1;
               pos_in     = '0;
               rec_on_in  = 1'b0;
               start      = 1'b1;
            end
         end
      end

      if (advance && play_on_in && !sound_busy && cmd == CMD_NONE) begin
         if (pos_in < count_in) begin
            cmd    = sound_cmd_type'(start ? first_ff : entry);
            pos_in = pos_in + CNT_W'(1);
         end else begin
            play_on_in = 1'b0;
            pos_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_on_ff  <= 1'b0;
         count_ff   <= '0;
         play_on_ff <= 1'b0;
         pos_ff     <= '0;
         byp_ff     <= 1'b0;
      end else begin
         rec_on_ff  <= rec_on_in;
         count_ff   <= count_in;
         play_on_ff <= play_on_in;
         pos_ff     <= pos_in;
         byp_ff     <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
      if (wr_en && count_ff == '0) begin
         first_ff <= wr_data;
      end
   end

   assign status.cmd       = cmd;
   assign status.recording = rec_on_in;
   assign status.playing   = play_on_in;
   assign status.count     = count_in;

endmodule
`default_nettype wire

// ----- sv/keypad_debounce_record_player_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_debounce_record_player_top
// Keypad poll decode and debounce, sound command issue, and command
// record / playback controller.
// ----------------------------------------------------------------------------
//  channel  direction  ports                          word
//  req      in         req_tvalid/tready/tdata[7:0]   one keypad poll
//  rsp      out        rsp_tvalid/tready/tdata[23:0]  one result per poll
//
//  One word is accepted per cycle while the result register is free or being drained;
//  its result passes the input register, then the result register, with a
//  combinational decode/debounce/sequencer path between the two registers.
//  Synchronous active-high reset clears all control state; the record store
//  is not cleared and needs no sweep, so words are taken right after reset.
//  A stalled rsp holds its word; req keeps taking words while the input register is
//  empty or the result register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module keypad_debounce_record_player_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [6:0] scan_bits, [7] sound_busy
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata    // [4:0] key_index, [6:5] debounce_state,
                                         // [8:7] sound_command, [9] recording,
                                         // [10] playing, [17:11] stored_count
);
   import kdrp_pkg::*;

   localparam logic [4:0] KEY_INDEX_NONE = 5'h1F;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [6:0] scan_ff;
   logic       busy_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff;

   logic           advance;
   logic           req_take;
   press_info_type press_info;
   seq_status_type seq_status;
   logic [4:0]     key_index;
   logic [23:0]    result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         scan_ff <= req_tdata[6:0];
         busy_ff <= req_tdata[7];
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   kdrp_debounce u_debounce (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .scan_bits  (scan_ff),
      .press_info (press_info)
   );

   kdrp_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sound_busy (busy_ff),
      .press_info (press_info),
      .status     (seq_status)
   );

   // no key reads as -1
   assign key_index = (press_info.key == NO_KEY) ? KEY_INDEX_NONE
                                                 : {1'b0, press_info.key};

   assign result = {6'd0,
                    7'(seq_status.count),
                    seq_status.playing,
                    seq_status.recording,
                    seq_status.cmd,
                    press_info.state,
                    key_index};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef NO_ASSERTIONS
   // the store count never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seq_status.count <= DEPTH_COUNT)
      else $error("stored count exceeds store depth");

   // a held press always comes with a decoded key in the same poll
   a_pressed_has_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6:5] == ST_ON) |-> (rsp_tdata[4:0] != KEY_INDEX_NONE))
      else $error("pressed state without a decoded key");

   // a result only appears after a poll went through the datapath
   a_result_from_poll: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance))
      else $error("result word without a processed poll");
`endif

endmodule
`default_nettype wire
